@@ design/ptd_pkg.sv @@
// Package for the periodic task dispatcher: field widths, command and status
// codes, controller states and default parameter values. No dependencies.
package ptd_pkg;

  localparam int NUM_SLOTS_DEF   = 8;
  localparam int PERIOD_BITS_DEF = 16;

  localparam int CMD_W     = 2;
  localparam int SLOT_FW   = 3;
  localparam int PERIOD_FW = 16;
  localparam int TASK_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int TICK_W    = 32;
  localparam int BIT_CNT_W = $clog2(TICK_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_CREATE   = 2'd1,
    CMD_DELETE   = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_RESERVED   = 2'd1,
    ST_NOT_FOUND  = 2'd2,
    ST_NONE_READY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_DIV,
    S_DEL,
    S_DISP,
    S_DISP_RD,
    S_DONE
  } state_t;

endpackage

@@ design/ptd_if.sv @@
// Valid/ready channel interfaces for the dispatcher: command beats in,
// result beats out. Depends on ptd_pkg.
interface ptd_in_if;
  import ptd_pkg::*;
  logic                 valid;
  logic                 ready;
  cmd_t                 cmd;
  logic [SLOT_FW-1:0]   slot;
  logic [PERIOD_FW-1:0] period;
  logic [TASK_W-1:0]    task_id;

  modport source(output valid, cmd, slot, period, task_id, input ready);
  modport sink(input valid, cmd, slot, period, task_id, output ready);
endinterface

interface ptd_out_if;
  import ptd_pkg::*;
  logic               valid;
  logic               ready;
  status_t            status;
  logic [SLOT_FW-1:0] found_slot;
  logic [TASK_W-1:0]  ready_task;

  modport source(output valid, status, found_slot, ready_task, input ready);
  modport sink(input valid, status, found_slot, ready_task, output ready);
endinterface

@@ design/ptd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ptd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/periodic_task_dispatcher.sv @@
// Periodic task dispatcher: slot table in one RAM (task id, period, phase),
// occupancy and ready flags in flops. Depends on ptd_pkg, ptd_if, ptd_ram.
// A tick does one RAM read-modify-write per slot; a create finishes directly or
// after a bit-serial tick_count % period (32 steps); a delete scans for the task
// id, and a dispatch scans the ready flags, then reads the task id from the RAM.
// Throughput: one item at a time; the next beat is taken while a result waits.
// Reset clears flags, tick count and scan pointer; RAM is not cleared.
module periodic_task_dispatcher #(
  parameter int NUM_SLOTS   = ptd_pkg::NUM_SLOTS_DEF,
  parameter int PERIOD_BITS = ptd_pkg::PERIOD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ptd_in_if.sink    in_chan,
  ptd_out_if.source out_chan
);
  import ptd_pkg::*;

  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int ENTRY_W = TASK_W + 2 * PERIOD_BITS;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  state_t                   state_r, state_nxt;
  logic [TICK_W-1:0]        tick_r, tick_nxt;
  logic [NUM_SLOTS-1:0]     occ_r, occ_nxt;
  logic [NUM_SLOTS-1:0]     rdy_r, rdy_nxt;
  logic [SLOT_W-1:0]        ptr_r, ptr_nxt;
  logic [SLOT_W-1:0]        idx_r, idx_nxt;
  logic [SLOT_W-1:0]        cnt_r, cnt_nxt;
  logic [SLOT_FW-1:0]       slot_r, slot_nxt;
  logic [PERIOD_BITS-1:0]   period_r, period_nxt;
  logic [TASK_W-1:0]        id_r, id_nxt;
  logic [TICK_W-1:0]        dvd_r, dvd_nxt;
  logic [PERIOD_BITS-1:0]   rem_r, rem_nxt;
  logic [BIT_CNT_W-1:0]     bit_r, bit_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic [SLOT_FW-1:0]       res_slot_r, res_slot_nxt;
  logic [TASK_W-1:0]        res_task_r, res_task_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [SLOT_FW-1:0]       out_slot_r, out_slot_nxt;
  logic [TASK_W-1:0]        out_task_r, out_task_nxt;

  logic                     ram_we;
  logic [SLOT_W-1:0]        ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]       ram_wdata, ram_rdata;
  logic [TASK_W-1:0]        rd_task;
  logic [PERIOD_BITS-1:0]   rd_period, rd_rem, rem_inc, new_rem;
  logic                     tick_hit;
  logic [PERIOD_BITS:0]     div_sh;
  logic [PERIOD_BITS-1:0]   rem_step;
  logic                     in_acc;
  logic                     slot_ok;
  logic [SLOT_W-1:0]        in_slot_idx;
  logic [PERIOD_BITS-1:0]   in_period;
  logic [SLOT_W-1:0]        idx_wrap;

  ptd_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_chan.ready    = (state_r == S_IDLE);
  assign in_acc           = in_chan.valid && in_chan.ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.found_slot = out_slot_r;
  assign out_chan.ready_task = out_task_r;

  assign slot_ok     = 32'(in_chan.slot) < 32'(NUM_SLOTS);
  assign in_slot_idx = SLOT_W'(in_chan.slot);
  assign in_period   = PERIOD_BITS'(in_chan.period);
  assign idx_wrap    = (idx_r == LAST_SLOT) ? '0 : idx_r + SLOT_W'(1);

  assign rd_task   = ram_rdata[ENTRY_W-1 -: TASK_W];
  assign rd_period = ram_rdata[2*PERIOD_BITS-1 -: PERIOD_BITS];
  assign rd_rem    = ram_rdata[PERIOD_BITS-1:0];

  // phase counter tracks tick_count % period; a wrap of the tick count restarts it
  assign rem_inc  = rd_rem + PERIOD_BITS'(1);
  assign new_rem  = (tick_r == '0 || rem_inc == rd_period) ? '0 : rem_inc;
  assign tick_hit = occ_r[idx_r] && (rd_period != '0) && (new_rem == '0);

  assign div_sh   = {rem_r, dvd_r[TICK_W-1]};
  assign rem_step = (div_sh >= {1'b0, period_r}) ?
                    PERIOD_BITS'(div_sh - {1'b0, period_r}) : PERIOD_BITS'(div_sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      occ_r       <= '0;
      rdy_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      occ_r       <= occ_nxt;
      rdy_r       <= rdy_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    slot_r       <= slot_nxt;
    period_r     <= period_nxt;
    id_r         <= id_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    bit_r        <= bit_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_task_r   <= res_task_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_task_r   <= out_task_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    tick_nxt       = tick_r;
    occ_nxt        = occ_r;
    rdy_nxt        = rdy_r;
    ptr_nxt        = ptr_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    slot_nxt       = slot_r;
    period_nxt     = period_r;
    id_nxt         = id_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    bit_nxt        = bit_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_task_nxt   = res_task_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_task_nxt   = out_task_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = {id_r, period_r, rem_step};
    ram_raddr      = idx_r + SLOT_W'(1);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          slot_nxt     = in_chan.slot;
          period_nxt   = in_period;
          id_nxt       = in_chan.task_id;
          res_task_nxt = '0;
          case (in_chan.cmd)
            CMD_TICK: begin
              tick_nxt       = tick_r + TICK_W'(1);
              idx_nxt        = '0;
              ram_raddr      = '0;
              res_status_nxt = ST_OK;
              res_slot_nxt   = '0;
              state_nxt      = S_TICK;
            end
            CMD_CREATE: begin
              res_slot_nxt = in_chan.slot;
              if (!slot_ok || occ_r[in_slot_idx]) begin
                res_status_nxt = ST_RESERVED;
                state_nxt      = S_DONE;
              end else if (in_chan.task_id == '0) begin
                rdy_nxt[in_slot_idx] = 1'b0;
                res_status_nxt       = ST_OK;
                state_nxt            = S_DONE;
              end else if (in_period == '0) begin
                ram_we               = 1'b1;
                ram_waddr            = in_slot_idx;
                ram_wdata            = {in_chan.task_id, {2*PERIOD_BITS{1'b0}}};
                occ_nxt[in_slot_idx] = 1'b1;
                rdy_nxt[in_slot_idx] = 1'b0;
                res_status_nxt       = ST_OK;
                state_nxt            = S_DONE;
              end else begin
                dvd_nxt   = tick_r;
                rem_nxt   = '0;
                bit_nxt   = '1;
                state_nxt = S_DIV;
              end
            end
            CMD_DELETE: begin
              res_slot_nxt = '0;
              if (in_chan.task_id == '0) begin
                res_status_nxt = ST_NOT_FOUND;
                state_nxt      = S_DONE;
              end else begin
                idx_nxt   = '0;
                ram_raddr = '0;
                state_nxt = S_DEL;
              end
            end
            CMD_DISPATCH: begin
              idx_nxt   = ptr_r;
              cnt_nxt   = '0;
              state_nxt = S_DISP;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_TICK: begin
        ram_we    = occ_r[idx_r];
        ram_wdata = {rd_task, rd_period, new_rem};
        if (tick_hit) begin
          rdy_nxt[idx_r] = 1'b1;
        end
        if (idx_r == LAST_SLOT) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end

      S_DIV: begin
        dvd_nxt = dvd_r << 1;
        rem_nxt = rem_step;
        bit_nxt = bit_r - BIT_CNT_W'(1);
        if (bit_r == '0) begin
          ram_we                   = 1'b1;
          ram_waddr                = SLOT_W'(slot_r);
          occ_nxt[SLOT_W'(slot_r)] = 1'b1;
          rdy_nxt[SLOT_W'(slot_r)] = 1'b0;
          res_status_nxt           = ST_OK;
          state_nxt                = S_DONE;
        end
      end

      S_DEL: begin
        if (occ_r[idx_r] && rd_task == id_r) begin
          occ_nxt[idx_r] = 1'b0;
          rdy_nxt[idx_r] = 1'b0;
          res_status_nxt = ST_OK;
          res_slot_nxt   = SLOT_FW'(idx_r);
          state_nxt      = S_DONE;
        end else if (idx_r == LAST_SLOT) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end

      S_DISP: begin
        if (rdy_r[idx_r]) begin
          ram_raddr      = idx_r;
          rdy_nxt[idx_r] = 1'b0;
          ptr_nxt        = idx_wrap;
          state_nxt      = S_DISP_RD;
        end else if (cnt_r == LAST_SLOT) begin
          res_status_nxt = ST_NONE_READY;
          res_slot_nxt   = '0;
          res_task_nxt   = '0;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = idx_wrap;
          cnt_nxt = cnt_r + SLOT_W'(1);
        end
      end

      S_DISP_RD: begin
        res_status_nxt = ST_OK;
        res_slot_nxt   = SLOT_FW'(idx_r);
        res_task_nxt   = rd_task;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_task_nxt   = res_task_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  a_ready_needs_task: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy_r & ~occ_r) == '0)
    else $error("ready flag set on an empty slot");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ptr_r) < 32'(NUM_SLOTS))
    else $error("scan pointer out of range");

  a_tick_inc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_chan.cmd == CMD_TICK |=> tick_r == $past(tick_r) + TICK_W'(1))
    else $error("tick count did not advance by one");

endmodule
